[hdl/ctp_pkg.sv]
// Shared constants, coefficient values, lookup tables and helpers for the cosine block.
package ctp_pkg;

    localparam int TableEntries = 128;
    localparam int IdxW         = 7;
    localparam int DxW          = 25;
    localparam int AccW         = 36;
    localparam int TabW         = 32;

    localparam longint unsigned DecOne = 64'd1000000000000000000;

    typedef logic signed [AccW-1:0] t_acc;
    typedef logic signed [TabW-1:0] t_tab_word;
    typedef t_tab_word t_tab [TableEntries];
    typedef longint signed t_quarter [TableEntries/4+1];

    // Unsigned quotient a / d by shift and subtract, used only while building constants.
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned d);
        longint unsigned rem;
        longint unsigned quo;
        rem = 64'd0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Decimal value n * 1e-18 rounded to the nearest Q32 value.
    function automatic longint unsigned dec_q32(input longint unsigned n);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = n;
        while (r >= DecOne) begin
            r = r - DecOne;
            q = q + 64'd1;
        end
        for (int i = 0; i < 33; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DecOne) begin
                q = q | 64'd1;
                r = r - DecOne;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    localparam longint unsigned PiQ32    = dec_q32(64'd3141592653589793238);
    localparam longint unsigned InvPiQ32 = dec_q32(64'd318309886183790672);

    localparam t_acc CoefS4 = t_acc'(dec_q32(64'd82145886611128229));
    localparam t_acc CoefS3 = t_acc'(dec_q32(64'd599264529320792077));
    localparam t_acc CoefS2 = t_acc'(dec_q32(64'd2550164039877345444));
    localparam t_acc CoefS1 = t_acc'(dec_q32(64'd5167712780049970029));
    localparam t_acc CoefS0 = t_acc'(PiQ32);
    localparam t_acc CoefC4 = t_acc'(dec_q32(64'd235330630358893205));
    localparam t_acc CoefC3 = t_acc'(dec_q32(64'd1335262768854589496));
    localparam t_acc CoefC2 = t_acc'(dec_q32(64'd4058712126416768218));
    localparam t_acc CoefC1 = t_acc'(dec_q32(64'd4934802200544679309));
    localparam t_acc OneQ32 = t_acc'(64'd1 << 32);

    // Quarter-wave Q30 sine (want_cos = 0) or cosine (want_cos = 1) from a Taylor series.
    function automatic t_quarter build_quarter(input bit want_cos);
        t_quarter res;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned ts;
        longint unsigned tc;
        longint signed ss;
        longint signed sc;
        longint unsigned dv;
        for (int k = 0; k <= TableEntries/4; k++) begin
            th  = (PiQ32 * longint'(k) + longint'(TableEntries/2)) >> IdxW;
            th2 = (th * th) >> 32;
            ts  = th;
            tc  = 64'd1 << 32;
            ss  = longint'(th);
            sc  = longint'(tc);
            for (int n = 1; n < 20; n++) begin
                dv = longint'(2*n) * longint'(2*n+1);
                ts = udiv64((ts * th2) >> 32, dv);
                dv = longint'(2*n-1) * longint'(2*n);
                tc = udiv64((tc * th2) >> 32, dv);
                ss = ((n & 1) == 1) ? ss - longint'(ts) : ss + longint'(ts);
                sc = ((n & 1) == 1) ? sc - longint'(tc) : sc + longint'(tc);
            end
            if (ss < 0) ss = 0;
            if (sc < 0) sc = 0;
            res[k] = want_cos ? ((sc + 2) >>> 2) : ((ss + 2) >>> 2);
        end
        return res;
    endfunction

    // Full sine (want_cos = 0) or cosine (want_cos = 1) table of pi*k/N in Q30.
    function automatic t_tab build_table(input bit want_cos);
        t_tab res;
        t_quarter qs;
        t_quarter qc;
        int j;
        longint signed v;
        qs = build_quarter(1'b0);
        qc = build_quarter(1'b1);
        for (int k = 0; k < TableEntries; k++) begin
            if (!want_cos) begin
                j = (k <= TableEntries/2) ? k : TableEntries - k;
                v = (j <= TableEntries/4) ? qs[j] : qc[TableEntries/2 - j];
            end else if (k <= TableEntries/2) begin
                j = TableEntries/2 - k;
                v = (j <= TableEntries/4) ? qs[j] : qc[TableEntries/2 - j];
            end else begin
                j = k - TableEntries/2;
                v = (j <= TableEntries/4) ? qs[j] : qc[TableEntries/2 - j];
                v = -v;
            end
            res[k] = t_tab_word'(v);
        end
        return res;
    endfunction

    localparam t_tab SinTab = build_table(1'b0);
    localparam t_tab CosTab = build_table(1'b1);

    // a * b / 2^32 with halves rounded away from zero.
    function automatic t_acc mul_rnd(input t_acc a, input logic [DxW-1:0] b);
        logic [AccW-1:0]     m;
        logic [AccW+DxW-1:0] p;
        m = a[AccW-1] ? AccW'(-a) : AccW'(a);
        p = (AccW+DxW)'(m) * (AccW+DxW)'(b) + ((AccW+DxW)'(1) << 31);
        m = AccW'(p[AccW+DxW-1:32]);
        return a[AccW-1] ? t_acc'(-m) : t_acc'(m);
    endfunction

endpackage

[hdl/ctp_poly.sv]
// Five-stage Horner pipeline for the sin(pi*dx) and cos(pi*dx) correction polynomials.
module ctp_poly (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ctp_pkg::DxW-1:0]   i_dx,
    input  logic [ctp_pkg::DxW-1:0]   i_dsq,
    output ctp_pkg::t_acc             o_sdx,
    output ctp_pkg::t_acc             o_cdx
);
    localparam int Depth = 4;

    logic [ctp_pkg::DxW-1:0] r_dx  [Depth];
    logic [ctp_pkg::DxW-1:0] r_dsq [Depth];
    ctp_pkg::t_acc           r_as  [Depth];
    ctp_pkg::t_acc           r_ac  [Depth];
    ctp_pkg::t_acc           r_sdx;
    ctp_pkg::t_acc           r_cdx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx[0]  <= i_dx;
            r_dsq[0] <= i_dsq;
            r_as[0]  <= ctp_pkg::mul_rnd(ctp_pkg::CoefS4, i_dsq) - ctp_pkg::CoefS3;
            r_ac[0]  <= ctp_pkg::mul_rnd(ctp_pkg::CoefC4, i_dsq) - ctp_pkg::CoefC3;
            r_dx[1]  <= r_dx[0];
            r_dsq[1] <= r_dsq[0];
            r_as[1]  <= ctp_pkg::mul_rnd(r_as[0], r_dsq[0]) + ctp_pkg::CoefS2;
            r_ac[1]  <= ctp_pkg::mul_rnd(r_ac[0], r_dsq[0]) + ctp_pkg::CoefC2;
            r_dx[2]  <= r_dx[1];
            r_dsq[2] <= r_dsq[1];
            r_as[2]  <= ctp_pkg::mul_rnd(r_as[1], r_dsq[1]) - ctp_pkg::CoefS1;
            r_ac[2]  <= ctp_pkg::mul_rnd(r_ac[1], r_dsq[1]) - ctp_pkg::CoefC1;
            r_dx[3]  <= r_dx[2];
            r_dsq[3] <= r_dsq[2];
            r_as[3]  <= ctp_pkg::mul_rnd(r_as[2], r_dsq[2]) + ctp_pkg::CoefS0;
            r_ac[3]  <= ctp_pkg::mul_rnd(r_ac[2], r_dsq[2]) + ctp_pkg::OneQ32;
            r_sdx    <= ctp_pkg::mul_rnd(r_as[3], r_dx[3]);
            r_cdx    <= r_ac[3];
        end
    end

    assign o_sdx = r_sdx;
    assign o_cdx = r_cdx;
endmodule

[hdl/cosine_table_polynomial.sv]
// Top level of the pipelined table-plus-polynomial cosine unit.
// Usage:
// The input channel carries a Q7.24 angle in radians on i_angle with i_valid;
// the block pushes back with o_stall. A transaction happens on a rising edge
// where i_valid is high and o_stall is low. The output channel carries the
// Q1.30 cosine on o_cosine with o_valid; the receiver pushes back with i_stall.
// Throughput is one transaction per cycle while the receiver does not stall;
// each result passes through nine register stages before o_valid rises:
// the phase multiply, the square of the offset, four Horner steps, the final
// offset multiply, the table products and the round/saturate step.
// When the receiver stalls while a result is waiting, the whole pipeline holds
// in place and o_stall rises, so nothing is dropped or repeated.
// The sine and cosine tables are constant logic, so no setup pass is needed.
// A synchronous active-low reset clears every valid bit; data registers are
// left as they are.
module cosine_table_polynomial #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_cosine
);
    localparam int Stages = 9;
    localparam int Dly    = 5;
    localparam int ProdW  = 68;
    localparam int SumW   = 69;

    logic [Stages-1:0] r_v;
    logic              w_en;

    logic [63:0]                   r_prod;
    logic [32:0]                   w_phase;
    logic [32:0]                   w_mag;
    logic [50:0]                   w_sq;
    logic [ctp_pkg::DxW-1:0]       r_dx;
    logic [ctp_pkg::DxW-1:0]       r_dsq;
    logic [ctp_pkg::IdxW-1:0]      r_idx;
    logic                          r_half;
    logic                          r_hd [Dly];
    ctp_pkg::t_tab_word            r_ct [Dly];
    ctp_pkg::t_tab_word            r_st [Dly];
    ctp_pkg::t_acc                 w_sdx;
    ctp_pkg::t_acc                 w_cdx;
    logic signed [ProdW-1:0]       r_p1;
    logic signed [ProdW-1:0]       r_p2;
    logic                          r_h8;
    logic signed [SumW-1:0]        w_sum;
    logic [SumW-1:0]               w_abs;
    logic [SumW-1:0]               w_rnd;
    logic [SumW-1:0]               w_m;
    logic signed [31:0]            r_cos;

    // The pipeline moves unless a finished result is held by the receiver.
    assign w_en    = !(r_v[Stages-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[Stages-2:0], i_valid};
        end
    end

    // Magnitude of the angle; the most negative code maps to exactly 2^31.
    assign w_mag   = i_angle[31] ? (33'h1_0000_0000 - {1'b0, i_angle}) : {1'b0, i_angle};
    assign w_phase = r_prod[ANGLE_FRAC_BITS+32:ANGLE_FRAC_BITS];
    // The rounded square of the largest offset carries into bit 50.
    assign w_sq    = 51'(w_phase[ctp_pkg::DxW-1:0]) * 51'(w_phase[ctp_pkg::DxW-1:0])
                   + (51'(1) << 31);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 64'(w_mag) * ctp_pkg::InvPiQ32;
            r_dx   <= w_phase[ctp_pkg::DxW-1:0];
            r_dsq  <= ctp_pkg::DxW'(w_sq[50:32]);
            r_idx  <= w_phase[31:ctp_pkg::DxW];
            r_half <= w_phase[32];
            // Table values and the half-turn flag travel alongside the polynomial stages.
            r_hd[0] <= r_half;
            r_ct[0] <= ctp_pkg::CosTab[r_idx];
            r_st[0] <= ctp_pkg::SinTab[r_idx];
            for (int i = 1; i < Dly; i++) begin
                r_hd[i] <= r_hd[i-1];
                r_ct[i] <= r_ct[i-1];
                r_st[i] <= r_st[i-1];
            end
            r_p1  <= ProdW'(r_ct[Dly-1]) * ProdW'(w_cdx);
            r_p2  <= ProdW'(r_st[Dly-1]) * ProdW'(w_sdx);
            r_h8  <= r_hd[Dly-1];
            r_cos <= ((w_sum < 0) != r_h8) ? 32'(-w_m) : 32'(w_m);
        end
    end

    ctp_poly u_poly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dx  (r_dx),
        .i_dsq (r_dsq),
        .o_sdx (w_sdx),
        .o_cdx (w_cdx)
    );

    // Round the Q62 difference to the result format, then clamp to one.
    assign w_sum = SumW'(r_p1) - SumW'(r_p2);
    assign w_abs = w_sum[SumW-1] ? SumW'(-w_sum) : SumW'(w_sum);
    assign w_rnd = (w_abs + (SumW'(1) << (61 - RESULT_FRAC_BITS))) >> (62 - RESULT_FRAC_BITS);
    assign w_m   = (w_rnd > (SumW'(1) << RESULT_FRAC_BITS)) ? (SumW'(1) << RESULT_FRAC_BITS)
                                                             : w_rnd;

    assign o_valid  = r_v[Stages-1];
    assign o_cosine = r_cos;
endmodule

[tb/sv/cosine_table_polynomial_test.sv]
`timescale 1ns / 1ps
// Testbench for the table-plus-polynomial cosine unit with a self-contained predictor.
module cosine_table_polynomial_test;

    localparam int NumEntries   = 128;
    localparam int AngleFrac    = 24;
    localparam int ResultFrac   = 30;
    localparam int RandomCount  = 550;
    localparam int IdleLimit    = 2000;
    localparam int DrainCycles  = 20;
    localparam longint unsigned DecUnit = 64'd1000000000000000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_angle;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_cosine;

    cosine_table_polynomial dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cosine (o_cosine)
    );

    // Predictor constants: Q32 coefficients and Q30 sine and cosine tables.
    longint signed   ks4, ks3, ks2, ks1, ks0, kc4, kc3, kc2, kc1;
    longint unsigned recip_pi;
    longint signed   sine_rom [NumEntries];
    longint signed   cosine_rom [NumEntries];
    longint signed   quarter_sin [NumEntries/4+1];
    longint signed   quarter_cos [NumEntries/4+1];

    logic signed [31:0] angle_queue [$];
    logic signed [31:0] cosine_queue [$];

    int  failures;
    int  accepted_in;
    int  accepted_out;
    int  idle_cycles;
    int  saturated_seen;
    bit  stimulus_done;
    int  burst_left;
    int  gap_left;
    int  stall_mode;

    // Decimal fixed point n * 1e-18 to nearest Q32.
    function automatic longint unsigned to_q32(input longint unsigned n);
        longint unsigned q;
        longint unsigned r;
        q = n / DecUnit;
        r = n % DecUnit;
        for (int i = 0; i < 33; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DecUnit) begin
                q = q | 64'd1;
                r = r - DecUnit;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    // Product scaled down by 2^32, halves rounded away from zero.
    function automatic longint signed scale_round(input longint signed a,
                                                  input longint unsigned b);
        longint unsigned mag;
        longint unsigned p;
        mag = a < 0 ? -a : a;
        p = (mag * b + (64'd1 << 31)) >> 32;
        return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint signed half_wave_sine(input int k);
        return k <= NumEntries/4 ? quarter_sin[k] : quarter_cos[NumEntries/2 - k];
    endfunction

    task automatic build_tables();
        longint unsigned pi_q;
        longint unsigned th, th2, ts, tc;
        longint signed   ss, sc;
        pi_q = to_q32(64'd3141592653589793238);
        ks4 = to_q32(64'd82145886611128229);
        ks3 = to_q32(64'd599264529320792077);
        ks2 = to_q32(64'd2550164039877345444);
        ks1 = to_q32(64'd5167712780049970029);
        ks0 = pi_q;
        kc4 = to_q32(64'd235330630358893205);
        kc3 = to_q32(64'd1335262768854589496);
        kc2 = to_q32(64'd4058712126416768218);
        kc1 = to_q32(64'd4934802200544679309);
        recip_pi = to_q32(64'd318309886183790672);
        for (int k = 0; k <= NumEntries/4; k++) begin
            th  = (pi_q * k + NumEntries/2) / NumEntries;
            th2 = (th * th) >> 32;
            ts  = th;
            tc  = 64'd1 << 32;
            ss  = th;
            sc  = tc;
            for (int n = 1; n < 20; n++) begin
                ts = ((ts * th2) >> 32) / (longint'(2*n) * (2*n+1));
                tc = ((tc * th2) >> 32) / (longint'(2*n-1) * (2*n));
                ss = (n % 2 == 1) ? ss - longint'(ts) : ss + longint'(ts);
                sc = (n % 2 == 1) ? sc - longint'(tc) : sc + longint'(tc);
            end
            if (ss < 0) ss = 0;
            if (sc < 0) sc = 0;
            quarter_sin[k] = (ss + 2) >>> 2;
            quarter_cos[k] = (sc + 2) >>> 2;
        end
        for (int k = 0; k < NumEntries; k++) begin
            sine_rom[k] = half_wave_sine(k <= NumEntries/2 ? k : NumEntries - k);
            cosine_rom[k] = k <= NumEntries/2 ? half_wave_sine(NumEntries/2 - k)
                                              : -half_wave_sine(k - NumEntries/2);
        end
    endtask

    // Expected Q1.30 cosine of one Q7.24 angle.
    function automatic logic signed [31:0] predict_cosine(input logic signed [31:0] angle);
        longint unsigned raw, mag, phase, frac, dx, dsq, rm;
        longint unsigned step;
        int              idx;
        bit              half_turn;
        longint signed   acc, sdx, cdx, total, res;
        step = (64'd1 << 32) / NumEntries;
        raw  = {32'd0, angle};
        mag  = angle[31] ? (64'd1 << 32) - raw : raw;
        phase = ((mag * recip_pi) >> AngleFrac) & 64'h1_FFFF_FFFF;
        half_turn = phase[32];
        frac = phase & 64'hFFFF_FFFF;
        idx  = int'(frac / step) & (NumEntries - 1);
        dx   = frac % step;
        dsq  = (dx * dx + (64'd1 << 31)) >> 32;
        acc = ks4;
        acc = scale_round(acc, dsq) - ks3;
        acc = scale_round(acc, dsq) + ks2;
        acc = scale_round(acc, dsq) - ks1;
        acc = scale_round(acc, dsq) + ks0;
        sdx = scale_round(acc, dx);
        acc = kc4;
        acc = scale_round(acc, dsq) - kc3;
        acc = scale_round(acc, dsq) + kc2;
        acc = scale_round(acc, dsq) - kc1;
        cdx = scale_round(acc, dsq) + (64'sd1 <<< 32);
        total = cosine_rom[idx] * cdx - sine_rom[idx] * sdx;
        rm = total < 0 ? -total : total;
        rm = (rm + (64'd1 << (61 - ResultFrac))) >> (62 - ResultFrac);
        if (rm > (64'd1 << ResultFrac)) rm = 64'd1 << ResultFrac;
        res = ((total < 0) != half_turn) ? -longint'(rm) : longint'(rm);
        return res[31:0];
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus: directed corners first, then random angles. Some random angles
    // stay near multiples of pi/128 steps and of pi so that table boundaries
    // and the saturation regions around multiples of pi are hit often.
    initial begin
        logic signed [31:0] corners [$];
        logic signed [31:0] a;
        int                 pick;
        build_tables();
        corners = '{32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001,
                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                    32'sh0324_3F6A, -32'sh0324_3F6A, 32'sh0192_1FB5,
                    32'sh0648_7ED5, 32'sh0000_6488, 32'sh0000_6487,
                    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0100_0000,
                    -32'sh0100_0000, 32'sh0000_FFFF, 32'sh7FFF_0000,
                    32'sh0C90_FDAA, 32'shFFFF_FF00};
        foreach (corners[i]) angle_queue.push_back(corners[i]);
        for (int n = 0; n < RandomCount; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                a = $urandom;
            end else if (pick < 7) begin
                a = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end else if (pick < 9) begin
                // Close to a table boundary: k*pi/128 plus a small offset.
                a = ($urandom_range(0, 8000) * 32'sd411775) + $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 1)) a = -a;
            end else begin
                // Close to a multiple of pi, where the result sits at plus or minus one.
                a = ($urandom_range(0, 40) * 32'sd52707179) + $urandom_range(0, 64) - 32;
                if ($urandom_range(0, 1)) a = -a;
            end
            angle_queue.push_back(a);
        end
        stimulus_done = 1'b1;
    end

    initial begin
        failures = 0;
        accepted_in = 0;
        accepted_out = 0;
        idle_cycles = 0;
        saturated_seen = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_angle = '0;
        i_stall = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: bursts of random length separated by random gaps. A held
    // transaction keeps its payload until the block takes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                void'(angle_queue.pop_front());
                cosine_queue.push_back(predict_cosine(i_angle));
                accepted_in <= accepted_in + 1;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (angle_queue.size() > 0) begin
                    i_valid <= 1'b1;
                    i_angle <= angle_queue[0];
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: phases of no stall, random stall and heavy stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Monitor: compare each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            accepted_out <= accepted_out + 1;
            if (o_cosine == 32'sh4000_0000 || o_cosine == -32'sh4000_0000)
                saturated_seen <= saturated_seen + 1;
            if (cosine_queue.size() == 0) begin
                $display("%0t: cosine result with nothing expected: actual %0d",
                         $time, o_cosine);
                failures <= failures + 1;
            end else begin
                want = cosine_queue.pop_front();
                if (o_cosine !== want) begin
                    $display("%0t: cosine mismatch: expected %0d, actual %0d",
                             $time, want, o_cosine);
                    failures <= failures + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side, and the end of the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no progress for %0d cycles, %0d results still expected",
                         $time, IdleLimit, cosine_queue.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        wait (angle_queue.size() == 0 && !i_valid);
        wait (cosine_queue.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        $display("Checked %0d angles (%0d directed corners plus random) against %0d results;",
                 accepted_in, 20, accepted_out);
        $display("%0d results were at plus or minus one.", saturated_seen);
        if (failures == 0 && cosine_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/ctp_pkg.sv
hdl/ctp_poly.sv
hdl/cosine_table_polynomial.sv
tb/sv/cosine_table_polynomial_test.sv
